// ===== hw/rtl/ipa_pkg.sv =====
// shared types and constants for the id pool allocator
`timescale 1ns / 1ps

package ipa_pkg;

  localparam int NUM_W          = 32;
  localparam int ST_W           = 2;
  localparam int FREE_SLOTS_DEF = 64;

  localparam logic [NUM_W-1:0] ALL_ONES = {NUM_W{1'b1}};

  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  localparam logic MODE_COUNTER_FIRST = 1'b0;
  localparam logic MODE_TABLE_FIRST   = 1'b1;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_DOUBLE    = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SRC_NONE    = 2'd0,
    SRC_COUNTER = 2'd1,
    SRC_TABLE   = 2'd2,
    SRC_RELEASE = 2'd3
  } src_t;

  typedef struct packed {
    logic clr_write;
    logic in_ready;
    logic scan;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic load;
    logic need_scan;
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

// ===== hw/rtl/ipa_if.sv =====
// request, result and configuration channel interfaces
`timescale 1ns / 1ps

interface ipa_req_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [ipa_pkg::NUM_W-1:0] release_value;

  modport source (output valid, output req_type, output release_value, input ready);
  modport sink   (input valid, input req_type, input release_value, output ready);
endinterface

interface ipa_res_if;
  logic                      valid;
  logic                      ready;
  logic [ipa_pkg::NUM_W-1:0] number;
  logic [ipa_pkg::ST_W-1:0]  status;

  modport source (output valid, output number, output status, input ready);
  modport sink   (input valid, input number, input status, output ready);
endinterface

interface ipa_cfg_if;
  logic valid;
  logic ready;
  logic withdrawal_mode;

  modport source (output valid, output withdrawal_mode, input ready);
  modport sink   (input valid, input withdrawal_mode, output ready);
endinterface

// ===== hw/rtl/ipa_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module ipa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/ipa_ctrl.sv =====
// controller state machine for the id pool allocator
`timescale 1ns / 1ps

module ipa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  ipa_pkg::dp_status_t sts,
  output ipa_pkg::ctl_cmd_t   cmd
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.load) begin
          state_nxt = sts.need_scan ? S_SCAN : S_FINISH;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/ipa_dpath.sv =====
// datapath: counter, free table, scan logic and result register
`timescale 1ns / 1ps

module ipa_dpath #(
  parameter int FREE_SLOTS = ipa_pkg::FREE_SLOTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ipa_pkg::ctl_cmd_t         cmd,
  output ipa_pkg::dp_status_t       sts,
  input  logic                      in_valid,
  input  logic                      in_req_type,
  input  logic [ipa_pkg::NUM_W-1:0] in_release_value,
  input  logic                      cfg_valid,
  input  logic                      cfg_withdrawal_mode,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ipa_pkg::NUM_W-1:0] out_number,
  output logic [ipa_pkg::ST_W-1:0]  out_status
);

  localparam int NW = ipa_pkg::NUM_W;
  localparam int WW = NW + 1;
  localparam int AW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
  localparam int CW = $clog2(FREE_SLOTS + 1);
  localparam logic [CW-1:0] SLOTS_C = CW'(FREE_SLOTS);
  localparam logic [CW-1:0] LAST_C  = CW'(FREE_SLOTS - 1);
  localparam logic [AW-1:0] LAST_A  = AW'(FREE_SLOTS - 1);

  // architectural state
  logic [NW-1:0]      next_unused_r;
  logic               exhausted_r;
  logic [CW-1:0]      count_r;
  logic               mode_r;

  // current request
  logic               req_type_r;
  logic [NW-1:0]      req_value_r;
  ipa_pkg::src_t      src_r;
  ipa_pkg::src_t      src_nxt;

  // scan
  logic [CW-1:0]      idx_r;
  logic               rd_valid_r;
  logic [AW-1:0]      rd_idx_r;
  logic               hit_r;
  logic [AW-1:0]      hit_idx_r;
  logic [NW-1:0]      hit_num_r;
  logic               spot_ok_r;
  logic [AW-1:0]      spot_idx_r;

  // result register
  logic               out_valid_r;
  logic [NW-1:0]      out_number_r;
  ipa_pkg::status_t   out_status_r;

  // ram ports
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [WW-1:0]      ram_wdata;
  logic [WW-1:0]      ram_rdata;

  logic               load;
  logic               tbl_avail;
  logic               ctr_avail;
  logic               eval_en;
  logic               slot_valid;
  logic [NW-1:0]      slot_num;
  logic               hit_now;
  logic               idx_in_range;
  logic [NW-1:0]      ctr_inc;
  logic               out_free;

  ipa_ram #(
    .WIDTH (WW),
    .DEPTH (FREE_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign load         = cmd.in_ready & in_valid;
  assign tbl_avail    = (count_r != '0);
  assign ctr_avail    = ~exhausted_r;
  assign idx_in_range = (idx_r < SLOTS_C);
  assign slot_valid   = ram_rdata[NW];
  assign slot_num     = ram_rdata[NW-1:0];
  assign eval_en      = cmd.scan & rd_valid_r;
  assign ctr_inc      = next_unused_r + NW'(1);
  assign out_free     = ~out_valid_r | out_ready;

  // source selection at accept time
  always_comb begin
    src_nxt = ipa_pkg::SRC_NONE;
    if (in_req_type == ipa_pkg::REQ_RELEASE) begin
      src_nxt = ipa_pkg::SRC_RELEASE;
    end else if (mode_r == ipa_pkg::MODE_COUNTER_FIRST) begin
      if (ctr_avail) begin
        src_nxt = ipa_pkg::SRC_COUNTER;
      end else if (tbl_avail) begin
        src_nxt = ipa_pkg::SRC_TABLE;
      end
    end else begin
      if (tbl_avail) begin
        src_nxt = ipa_pkg::SRC_TABLE;
      end else if (ctr_avail) begin
        src_nxt = ipa_pkg::SRC_COUNTER;
      end
    end
  end

  always_comb begin
    if (req_type_r == ipa_pkg::REQ_RELEASE) begin
      hit_now = eval_en & slot_valid & (slot_num == req_value_r);
    end else begin
      hit_now = eval_en & slot_valid;
    end
  end

  always_comb begin
    sts.clr_last  = (idx_r == LAST_C);
    sts.load      = load;
    sts.need_scan = (src_nxt == ipa_pkg::SRC_TABLE) || (src_nxt == ipa_pkg::SRC_RELEASE);
    sts.scan_done = eval_en & (hit_now | (rd_idx_r == LAST_A));
    sts.out_free  = out_free;
  end

  // table write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r[AW-1:0];
    ram_wdata = '0;
    if (cmd.clr_write) begin
      ram_we = 1'b1;
    end else if (cmd.commit) begin
      if (src_r == ipa_pkg::SRC_TABLE) begin
        ram_we    = 1'b1;
        ram_waddr = hit_idx_r;
        ram_wdata = {1'b0, hit_num_r};
      end else if ((src_r == ipa_pkg::SRC_RELEASE) && !hit_r && spot_ok_r) begin
        ram_we    = 1'b1;
        ram_waddr = spot_idx_r;
        ram_wdata = {1'b1, req_value_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      req_type_r  <= in_req_type;
      req_value_r <= in_release_value;
      src_r       <= src_nxt;
    end
    rd_idx_r <= idx_r[AW-1:0];
    if (hit_now) begin
      hit_idx_r <= rd_idx_r;
      hit_num_r <= slot_num;
    end
    if (eval_en && !slot_valid) begin
      spot_idx_r <= rd_idx_r;
    end
    if (cmd.commit) begin
      unique case (src_r)
        ipa_pkg::SRC_COUNTER: begin
          out_number_r <= next_unused_r;
          out_status_r <= ipa_pkg::ST_OK;
        end
        ipa_pkg::SRC_TABLE: begin
          out_number_r <= hit_num_r;
          out_status_r <= ipa_pkg::ST_OK;
        end
        ipa_pkg::SRC_NONE: begin
          out_number_r <= '0;
          out_status_r <= ipa_pkg::ST_EXHAUSTED;
        end
        ipa_pkg::SRC_RELEASE: begin
          out_number_r <= '0;
          if (hit_r) begin
            out_status_r <= ipa_pkg::ST_DOUBLE;
          end else if (!spot_ok_r) begin
            out_status_r <= ipa_pkg::ST_FULL;
          end else begin
            out_status_r <= ipa_pkg::ST_OK;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_unused_r <= '0;
      exhausted_r   <= 1'b0;
      count_r       <= '0;
      mode_r        <= ipa_pkg::MODE_COUNTER_FIRST;
      idx_r         <= '0;
      rd_valid_r    <= 1'b0;
      hit_r         <= 1'b0;
      spot_ok_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        mode_r <= cfg_withdrawal_mode;
      end
      rd_valid_r <= cmd.scan & idx_in_range;
      if (load) begin
        idx_r     <= '0;
        hit_r     <= 1'b0;
        spot_ok_r <= 1'b0;
      end else if (cmd.clr_write || (cmd.scan && idx_in_range)) begin
        idx_r <= idx_r + CW'(1);
      end
      if (hit_now) begin
        hit_r <= 1'b1;
      end
      if (eval_en && !slot_valid) begin
        spot_ok_r <= 1'b1;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
        unique case (src_r)
          ipa_pkg::SRC_COUNTER: begin
            next_unused_r <= ctr_inc;
            if (ctr_inc == ipa_pkg::ALL_ONES) begin
              exhausted_r <= 1'b1;
            end
          end
          ipa_pkg::SRC_TABLE: begin
            count_r <= count_r - CW'(1);
          end
          ipa_pkg::SRC_NONE: begin
          end
          ipa_pkg::SRC_RELEASE: begin
            if (!hit_r && spot_ok_r) begin
              count_r <= count_r + CW'(1);
            end
          end
        endcase
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_number = out_number_r;
  assign out_status = out_status_r;

endmodule

// ===== hw/rtl/id_pool_allocator.sv =====
// top level of the 32-bit id pool allocator
// usage:
//   in_if   request items: req_type 0 allocates a number, 1 releases release_value
//   out_if  one result item per request: number (0 unless an allocate succeeds) and
//           status (0 ok, 1 pool exhausted, 2 already released, 3 free table full)
//   cfg_if  withdrawal_mode, 0 hands out never-used numbers first, 1 released ones
//           first; always ready, write it only while no request is in flight
// request flow:
//   an allocate served by the counter, or one that fails, goes from accept to the
//   finish state and then to the output register; an allocate served by the free
//   table, and a release, first pass through the scan state, which reads the free
//   table one entry per cycle through its single read port until a hit or the last entry
//   one request is in flight at a time; the next is taken once the current result
//   has been written to the output register
// reset:
//   rst_n clears the counter and the mode, then a clearing pass writes every free
//   table entry empty in turn, during which no request is accepted
// stall:
//   a held result stays in the output register; a new request is still accepted,
//   and its result waits in the datapath until the output register frees
`timescale 1ns / 1ps

module id_pool_allocator #(
  parameter int FREE_SLOTS = ipa_pkg::FREE_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ipa_req_if.sink   in_if,
  ipa_res_if.source out_if,
  ipa_cfg_if.sink   cfg_if
);

  ipa_pkg::ctl_cmd_t   cmd;
  ipa_pkg::dp_status_t sts;

  ipa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  ipa_dpath #(
    .FREE_SLOTS (FREE_SLOTS)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_valid            (in_if.valid),
    .in_req_type         (in_if.req_type),
    .in_release_value    (in_if.release_value),
    .cfg_valid           (cfg_if.valid),
    .cfg_withdrawal_mode (cfg_if.withdrawal_mode),
    .out_valid           (out_if.valid),
    .out_ready           (out_if.ready),
    .out_number          (out_if.number),
    .out_status          (out_if.status)
  );

  assign in_if.ready  = cmd.in_ready;
  assign cfg_if.ready = 1'b1;

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for the id pool allocator: directed and random requests
`timescale 1ns / 1ps

module testbench;

  localparam int CHUNKS        = 8;
  localparam int CHUNK_ITEMS   = 68;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = ipa_pkg::FREE_SLOTS_DEF + 8;
  localparam int MAX_GAP       = 40;
  localparam int MAX_REPORTS   = 10;
  localparam int POOL_LIMIT    = 256;

  typedef struct {
    logic [ipa_pkg::NUM_W-1:0] number;
    ipa_pkg::status_t          status;
  } pool_result_t;

  class pool_tracker;
    logic [ipa_pkg::NUM_W-1:0] next_unused;
    bit                        counter_done;
    bit                        slot_used [ipa_pkg::FREE_SLOTS_DEF];
    logic [ipa_pkg::NUM_W-1:0] slot_val [ipa_pkg::FREE_SLOTS_DEF];
    logic                      mode;
    pool_result_t              due_results[$];
    logic [ipa_pkg::NUM_W-1:0] handed_out[$];
    int mismatches, checked;
    int n_counter, n_table, n_stored, n_double, n_full, n_exhausted;

    function void clear_state();
      next_unused  = '0;
      counter_done = 1'b0;
      mode         = ipa_pkg::MODE_COUNTER_FIRST;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
    endfunction

    function bit take_from_counter(output logic [ipa_pkg::NUM_W-1:0] n);
      n = '0;
      if (counter_done) return 1'b0;
      n = next_unused;
      next_unused = next_unused + 1;
      if (next_unused == ipa_pkg::ALL_ONES) counter_done = 1'b1;
      n_counter++;
      return 1'b1;
    endfunction

    function bit take_lowest_slot(output logic [ipa_pkg::NUM_W-1:0] n);
      n = '0;
      for (int i = 0; i < ipa_pkg::FREE_SLOTS_DEF; i++) begin
        if (slot_used[i]) begin
          n = slot_val[i];
          slot_used[i] = 1'b0;
          n_table++;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_request(logic rt, logic [ipa_pkg::NUM_W-1:0] v);
      pool_result_t r;
      bit got, dup, have_spot;
      int spot;
      r.number  = '0;
      r.status  = ipa_pkg::ST_OK;
      dup       = 1'b0;
      have_spot = 1'b0;
      spot      = 0;
      if (rt == ipa_pkg::REQ_RELEASE) begin
        for (int i = 0; i < ipa_pkg::FREE_SLOTS_DEF; i++) begin
          if (slot_used[i]) begin
            if (slot_val[i] == v) dup = 1'b1;
          end else begin
            spot = i;
            have_spot = 1'b1;
          end
        end
        if (dup) begin
          r.status = ipa_pkg::ST_DOUBLE;
          n_double++;
        end else if (!have_spot) begin
          r.status = ipa_pkg::ST_FULL;
          n_full++;
        end else begin
          slot_used[spot] = 1'b1;
          slot_val[spot]  = v;
          n_stored++;
        end
      end else begin
        if (mode == ipa_pkg::MODE_COUNTER_FIRST) begin
          if (counter_done) got = take_lowest_slot(r.number);
          else got = take_from_counter(r.number);
        end else begin
          got = take_lowest_slot(r.number);
          if (!got) got = take_from_counter(r.number);
        end
        if (got) begin
          handed_out.push_back(r.number);
          if (handed_out.size() > POOL_LIMIT) void'(handed_out.pop_front());
        end else begin
          r.number = '0;
          r.status = ipa_pkg::ST_EXHAUSTED;
          n_exhausted++;
        end
      end
      due_results.push_back(r);
    endfunction

    function void check_result(logic [ipa_pkg::NUM_W-1:0] num, logic [ipa_pkg::ST_W-1:0] st);
      pool_result_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result item number=%h status=%0d", $realtime, num, st);
        return;
      end
      want = due_results.pop_front();
      checked++;
      if (num !== want.number || st !== want.status) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result %0d mismatch: number exp %h got %h, status exp %0d got %0d",
                   $realtime, checked, want.number, num, want.status, st);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   sender_idle_pct;
  int   stall_pct;
  bit   hold_req;
  int   n_requests;
  pool_tracker sb;

  ipa_req_if req_ch();
  ipa_res_if res_ch();
  ipa_cfg_if cfg_ch();

  id_pool_allocator #(
    .FREE_SLOTS(ipa_pkg::FREE_SLOTS_DEF)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (req_ch),
    .out_if(res_ch),
    .cfg_if(cfg_ch)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic send_item(input logic rt, input logic [ipa_pkg::NUM_W-1:0] v);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.req_type      <= rt;
    req_ch.release_value <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(rt, v);
    n_requests++;
  endtask

  task automatic settle_pool();
    req_ch.valid <= 1'b0;
    while (sb.due_results.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    cfg_ch.valid           <= 1'b1;
    cfg_ch.withdrawal_mode <= m;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    sb.mode = m;
  endtask

  task automatic run_chunk(input int k);
    logic                      m, rt;
    logic [ipa_pkg::NUM_W-1:0] v;
    logic [ipa_pkg::NUM_W-1:0] stored[$];
    int                        fill, kind, idx, alloc_pct, occupied;
    m = k[0] ^ k[2];
    case (k % 4)
      0: begin sender_idle_pct = 0;  stall_pct = 0;  end
      1: begin sender_idle_pct = 75; stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  stall_pct = 75; end
      default: begin sender_idle_pct = 12; stall_pct = 12; end
    endcase
    write_mode(m);
    if (k == 0) hold_req = 1'b1;
    occupied = 0;
    foreach (sb.slot_used[i]) occupied += sb.slot_used[i];
    // counter-first phases start by filling the free table past its limit
    fill = (m == ipa_pkg::MODE_COUNTER_FIRST) ? ipa_pkg::FREE_SLOTS_DEF - occupied + 3 : 0;
    alloc_pct = (m == ipa_pkg::MODE_TABLE_FIRST) ? 50 : 35;
    for (int n = 0; n < CHUNK_ITEMS; n++) begin
      v  = $urandom;
      rt = ipa_pkg::REQ_RELEASE;
      if (n >= fill) begin
        kind = $urandom_range(99);
        if (kind < alloc_pct) begin
          rt = ipa_pkg::REQ_ALLOC;
        end else if (kind < alloc_pct + 25 && sb.handed_out.size() > 0) begin
          idx = $urandom_range(sb.handed_out.size() - 1);
          v = sb.handed_out[idx];
          sb.handed_out.delete(idx);
        end else if (kind < alloc_pct + 45) begin
          stored.delete();
          foreach (sb.slot_used[i]) if (sb.slot_used[i]) stored.push_back(sb.slot_val[i]);
          if (stored.size() > 0) v = stored[$urandom_range(stored.size() - 1)];
        end else if (kind < alloc_pct + 52) begin
          case ($urandom_range(3))
            0: v = '0;
            1: v = ipa_pkg::ALL_ONES;
            2: v = ipa_pkg::ALL_ONES - 1;
            default: v = 32'h1 << $urandom_range(ipa_pkg::NUM_W - 1);
          endcase
        end
      end
      send_item(rt, v);
    end
    settle_pool();
  endtask

  initial begin
    int hold_left;
    hold_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_ch.valid && res_ch.ready) sb.check_result(res_ch.number, res_ch.status);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("testbench failed");
    $finish;
  end

  initial begin
    sb = new();
    sb.clear_state();
    sender_idle_pct = 0;
    stall_pct       = 0;
    hold_req        = 1'b0;
    n_requests      = 0;
    rst_n                  <= 1'b0;
    req_ch.valid           <= 1'b0;
    req_ch.req_type        <= ipa_pkg::REQ_ALLOC;
    req_ch.release_value   <= '0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.withdrawal_mode <= ipa_pkg::MODE_COUNTER_FIRST;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // counter first: releases are stored in the table but never drawn from
    write_mode(ipa_pkg::MODE_COUNTER_FIRST);
    send_item(ipa_pkg::REQ_ALLOC, 32'h1234_5678);
    send_item(ipa_pkg::REQ_ALLOC, ipa_pkg::ALL_ONES);
    send_item(ipa_pkg::REQ_RELEASE, '0);
    send_item(ipa_pkg::REQ_RELEASE, '0);
    send_item(ipa_pkg::REQ_RELEASE, ipa_pkg::ALL_ONES);
    send_item(ipa_pkg::REQ_RELEASE, ipa_pkg::ALL_ONES - 1);
    send_item(ipa_pkg::REQ_RELEASE, ipa_pkg::ALL_ONES);
    send_item(ipa_pkg::REQ_ALLOC, '0);
    send_item(ipa_pkg::REQ_RELEASE, 32'h8000_0000);
    settle_pool();

    // table first: lowest slot out, then fall back to the counter
    write_mode(ipa_pkg::MODE_TABLE_FIRST);
    send_item(ipa_pkg::REQ_ALLOC, '0);
    send_item(ipa_pkg::REQ_ALLOC, '0);
    send_item(ipa_pkg::REQ_ALLOC, '0);
    send_item(ipa_pkg::REQ_ALLOC, '0);
    send_item(ipa_pkg::REQ_ALLOC, ipa_pkg::ALL_ONES);
    send_item(ipa_pkg::REQ_ALLOC, '0);
    send_item(ipa_pkg::REQ_RELEASE, 32'hAAAA_AAAA);
    send_item(ipa_pkg::REQ_RELEASE, 32'h5555_5555);
    send_item(ipa_pkg::REQ_RELEASE, 32'hAAAA_AAAA);
    send_item(ipa_pkg::REQ_ALLOC, '0);
    send_item(ipa_pkg::REQ_RELEASE, 32'h0000_0001);
    settle_pool();

    for (int k = 0; k < CHUNKS; k++) run_chunk(k);

    $display("%0d requests: %0d counter and %0d table allocations, %0d releases stored",
             n_requests, sb.n_counter, sb.n_table, sb.n_stored);
    $display("%0d double releases, %0d full-table refusals, %0d exhausted, %0d results checked",
             sb.n_double, sb.n_full, sb.n_exhausted, sb.checked);
    if (sb.due_results.size() > 0)
      $display("%0d expected results never arrived", sb.due_results.size());
    if (sb.mismatches > MAX_REPORTS)
      $display("%0d mismatches in total", sb.mismatches);
    if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== id_pool_allocator.f =====
hw/rtl/ipa_pkg.sv
hw/rtl/ipa_if.sv
hw/rtl/ipa_ram.sv
hw/rtl/ipa_ctrl.sv
hw/rtl/ipa_dpath.sv
hw/rtl/id_pool_allocator.sv
test/testbench.sv
